// ----- rtl/rbd_pkg.sv -----
// Package for the ring buffer deque: sizes, command and status codes, payload types.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CFG_W = 5;
  localparam int DATA_W = 32;
  localparam int CAP_RESET_INT = (DEPTH < 16) ? DEPTH : 16;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAP_RESET_INT);

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_code_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ring_buffer_deque.sv -----
// Double-ended queue over a circular slot memory with a registered read port.
//
//  Channel   Signals                  Direction  Transfer
//  command   start, busy, req         in         start high and busy low at a clock edge
//  result    done, rsp                out        done high for one cycle, always taken
//  config    cfg_we, cfg_data         in         cfg_we high at a clock edge
//
// For each command the slot read is issued at the transfer edge and the
// read-modify-write of slots and indices happens in the following cycle, as the memory
// has one registered read port. The result shows the cycle after that,
// while the next command may already be transferred.
// Synchronous reset empties the queue and sets the capacity to sixteen; slot contents
// are not cleared. The receiver cannot stall, so the result is never held.
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_deque (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rbd_pkg::req_t               req,
  output logic                             done,
  output rbd_pkg::rsp_t                    rsp,
  input  wire logic                        cfg_we,
  input  wire logic [rbd_pkg::CFG_W-1:0]   cfg_data
);

  localparam int IDX_W = rbd_pkg::IDX_W;
  localparam int CNT_W = rbd_pkg::CNT_W;
  localparam int DATA_W = rbd_pkg::DATA_W;

  rbd_pkg::state_t state, state_next;
  rbd_pkg::req_t   req_q;
  rbd_pkg::rsp_t   rsp_next;
  logic            done_next;

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [CNT_W-1:0] capacity, capacity_cfg;

  logic [DATA_W-1:0] mem [rbd_pkg::DEPTH];
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;
  logic              ram_we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;

  logic accept;

  function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(i) + CNT_W'(1);
    return (n >= cap) ? IDX_W'(0) : n[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] last;
    last = cap - CNT_W'(1);
    return (i == IDX_W'(0) || CNT_W'(i) >= cap) ? last[IDX_W-1:0] : i - IDX_W'(1);
  endfunction

  assign busy   = (state != rbd_pkg::S_IDLE);
  assign accept = start && !busy;

  // Front reads come from the head, back reads from the tail.
  assign raddr = (req.cmd == rbd_pkg::CMD_POP_FRONT || req.cmd == rbd_pkg::CMD_PEEK_FRONT)
               ? head : tail;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    if (cfg_data == '0) begin
      capacity_cfg = CNT_W'(1);
    end else if (32'(cfg_data) > 32'(rbd_pkg::DEPTH)) begin
      capacity_cfg = CNT_W'(rbd_pkg::DEPTH);
    end else begin
      capacity_cfg = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    rsp <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rbd_pkg::S_IDLE;
      done        <= 1'b0;
      head        <= '0;
      tail        <= '0;
      entry_count <= '0;
      capacity    <= rbd_pkg::CAP_RESET;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) begin
        // A capacity write also empties the queue.
        capacity    <= capacity_cfg;
        head        <= '0;
        tail        <= '0;
        entry_count <= '0;
      end else begin
        head        <= head_next;
        tail        <= tail_next;
        entry_count <= entry_count_next;
      end
    end
  end

  always_comb begin
    state_next       = state;
    done_next        = 1'b0;
    head_next        = head;
    tail_next        = tail;
    entry_count_next = entry_count;
    ram_we           = 1'b0;
    waddr            = head;
    wdata            = req_q.push_value;
    rsp_next         = rsp;

    unique case (state)
      rbd_pkg::S_IDLE: begin
        if (accept) begin
          state_next = rbd_pkg::S_EXEC;
        end
      end
      rbd_pkg::S_EXEC: begin
        state_next          = rbd_pkg::S_IDLE;
        done_next           = 1'b1;
        rsp_next.read_value = '0;
        rsp_next.status     = rbd_pkg::ST_OK;
        case (req_q.cmd) inside
          rbd_pkg::CMD_PUSH_FRONT, rbd_pkg::CMD_PUSH_BACK: begin
            if (entry_count >= capacity) begin
              rsp_next.status = rbd_pkg::ST_FULL;
            end else begin
              ram_we           = 1'b1;
              entry_count_next = entry_count + CNT_W'(1);
              if (entry_count == '0) begin
                head_next = '0;
                tail_next = '0;
                waddr     = '0;
              end else if (req_q.cmd == rbd_pkg::CMD_PUSH_FRONT) begin
                head_next = wrap_down(head, capacity);
                waddr     = head_next;
              end else begin
                tail_next = wrap_up(tail, capacity);
                waddr     = tail_next;
              end
            end
          end
          rbd_pkg::CMD_POP_FRONT, rbd_pkg::CMD_POP_BACK,
          rbd_pkg::CMD_PEEK_FRONT, rbd_pkg::CMD_PEEK_BACK: begin
            if (entry_count == '0) begin
              rsp_next.status = rbd_pkg::ST_EMPTY;
            end else begin
              rsp_next.read_value = rdata;
              if (req_q.cmd == rbd_pkg::CMD_POP_FRONT) begin
                head_next        = wrap_up(head, capacity);
                entry_count_next = entry_count - CNT_W'(1);
              end else if (req_q.cmd == rbd_pkg::CMD_POP_BACK) begin
                tail_next        = wrap_down(tail, capacity);
                entry_count_next = entry_count - CNT_W'(1);
              end
            end
          end
          default: begin
          end
        endcase
        rsp_next.count = entry_count_next;
      end
      default: begin
        state_next = rbd_pkg::S_IDLE;
      end
    endcase
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= capacity)
    else $error("entry count exceeds capacity");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == rbd_pkg::S_EXEC))
    else $error("result strobe without an executed command");

  a_full_at_capacity: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == rbd_pkg::ST_FULL) |-> (rsp.count == capacity))
    else $error("full status while below capacity");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == rbd_pkg::ST_EMPTY) |-> (rsp.count == '0 && rsp.read_value == '0))
    else $error("empty status with entries or data");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == rbd_pkg::S_EXEC))
    else $error("slot write outside execution");

endmodule

`default_nettype wire

// ----- tb/sv/rbd_checker.sv -----
// Checker for the ring buffer deque: predicts each result and compares it with the block's output.
`timescale 1ns / 1ps

module rbd_checker
  import rbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  req_t             req,
  input  logic             done,
  input  rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               full_seen,
  output int               empty_seen
);

  logic [DATA_W-1:0] slot_mem [DEPTH];
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  cap;
  rsp_t              expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    full_seen  = 0;
    empty_seen = 0;
  end

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (int'(v) > DEPTH) return CNT_W'(DEPTH);
    return CNT_W'(v);
  endfunction

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
    int n;
    n = int'(i) + 1;
    return (n >= int'(cap)) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
    if (i == '0 || int'(i) >= int'(cap)) return IDX_W'(int'(cap) - 1);
    return i - 1'b1;
  endfunction

  // Applies one command to the predicted queue and returns the result it should give.
  function automatic rsp_t apply_command(input req_t r);
    rsp_t o;
    o = '0;
    case (r.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill >= cap) begin
          o.status = ST_FULL;
        end else begin
          // A push into an empty queue restarts both ends at slot zero.
          if (fill == '0) begin
            head = '0;
            tail = '0;
            slot_mem[0] = r.push_value;
          end else if (r.cmd == CMD_PUSH_FRONT) begin
            head = step_down(head);
            slot_mem[head] = r.push_value;
          end else begin
            tail = step_up(tail);
            slot_mem[tail] = r.push_value;
          end
          fill = fill + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (fill == '0) begin
          o.status = ST_EMPTY;
        end else begin
          if (r.cmd == CMD_POP_FRONT || r.cmd == CMD_PEEK_FRONT) o.read_value = slot_mem[head];
          else o.read_value = slot_mem[tail];
          if (r.cmd == CMD_POP_FRONT) begin
            head = step_up(head);
            fill = fill - 1'b1;
          end else if (r.cmd == CMD_POP_BACK) begin
            tail = step_down(tail);
            fill = fill - 1'b1;
          end
        end
      end
      default: ;
    endcase
    o.count = fill;
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      head = '0;
      tail = '0;
      fill = '0;
      cap  = CAP_RESET;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: value %0d status %0d count %0d",
                     rsp.read_value, rsp.status, rsp.count);
        end else begin
          want = expected_results.pop_front();
          if (rsp.read_value !== want.read_value || rsp.status !== want.status ||
              rsp.count !== want.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected value %0d status %0d count %0d,",
                       want.read_value, want.status, want.count,
                       " got value %0d status %0d count %0d",
                       rsp.read_value, rsp.status, rsp.count);
          end
        end
      end
      // A capacity write also empties the queue; slot contents survive.
      if (cfg_we) begin
        cap  = clamp_cap(cfg_data);
        head = '0;
        tail = '0;
        fill = '0;
      end
      if (start && !busy) begin
        want = apply_command(req);
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/sv/tb_ring_buffer_deque.sv -----
// Top of the ring buffer deque testbench: clock, reset, command and capacity stimulus, verdict.
`timescale 1ns / 1ps

module tb_ring_buffer_deque;
  import rbd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 160;
  localparam int PHASES = 10;
  // Command codes the block does not define; they must leave the queue alone.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  req_t             req = '0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             busy;
  logic             done;
  rsp_t             rsp;

  int fail_count;
  int pending;
  int full_seen;
  int empty_seen;
  int cycles = 0;
  int sent = 0;
  int cap_writes = 0;
  bit idle_on = 1'b0;

  ring_buffer_deque DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  rbd_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .full_seen  (full_seen),
    .empty_seen (empty_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_ring_buffer_deque NOT OK");
      $finish;
    end
  end

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Holds one command until its transfer, then maybe idles for a burst.
  task automatic issue(input logic [2:0] c, input logic [DATA_W-1:0] v);
    start <= 1'b1;
    req.cmd <= c;
    req.push_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (idle_on && $urandom_range(0, 7) == 0) pause($urandom_range(1, 15));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_writes++;
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_take();
    case ($urandom_range(0, 3))
      0: return CMD_POP_FRONT;
      1: return CMD_POP_BACK;
      2: return CMD_PEEK_FRONT;
      default: return CMD_PEEK_BACK;
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
    case (mix)
      MIX_FILL:  if (r < 70) return ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      MIX_DRAIN: if (r < 25) return ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      default:   if (r < 45) return ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    endcase
    return pick_take();
  endfunction

  initial begin
    int   cap_plan[PHASES];
    mix_t mix;
    cap_plan = '{16, 1, 0, 31, 17, 2, 3, 5, 8, 16};
    cap_plan[8] = $urandom_range(0, 31);
    mix = MIX_EVEN;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every command on an empty queue, the word extremes, both ends,
    // spare codes, a push into a drained queue and a full queue at capacity one.
    issue(CMD_POP_FRONT, '0);
    issue(CMD_POP_BACK, '0);
    issue(CMD_PEEK_FRONT, '0);
    issue(CMD_PEEK_BACK, '0);
    issue(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    issue(CMD_PUSH_FRONT, 32'h8000_0000);
    issue(CMD_PEEK_FRONT, '1);
    issue(CMD_PEEK_BACK, '1);
    issue(CMD_PUSH_BACK, '0);
    issue(CMD_PUSH_FRONT, '1);
    issue(CMD_SPARE_A, 32'h1234_5678);
    issue(CMD_SPARE_B, 32'h8765_4321);
    issue(CMD_POP_BACK, '0);
    issue(CMD_POP_FRONT, '0);
    issue(CMD_POP_FRONT, '0);
    issue(CMD_POP_BACK, '0);
    issue(CMD_PUSH_FRONT, 32'h5A5A_A5A5);
    issue(CMD_PEEK_BACK, '0);
    write_capacity(CFG_W'(1));
    issue(CMD_PUSH_BACK, 32'hA5A5_5A5A);
    issue(CMD_PUSH_FRONT, 32'h0F0F_F0F0);
    issue(CMD_PEEK_FRONT, '0);
    // A capacity write with an entry still stored must leave the queue empty.
    write_capacity(CFG_W'(0));
    issue(CMD_PEEK_BACK, '0);
    issue(CMD_POP_FRONT, '0);

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(CFG_W'(cap_plan[p]));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 32 == 0) begin
          mix = mix_t'($urandom_range(0, 2));
          idle_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
        end
        // Hold the sender until the block has answered everything outstanding.
        if (i == PHASE_ITEMS / 2) drain();
        issue(pick_cmd(mix), pick_word());
      end
    end
    drain();

    $display("Run covered %0d commands over %0d capacity writes (0 to 31 requested),",
             sent, cap_writes);
    $display("with %0d pushes refused as full and %0d reads answered as empty.",
             full_seen, empty_seen);
    if (fail_count == 0) begin
      $display("tb_ring_buffer_deque OK");
    end else begin
      $display("tb_ring_buffer_deque NOT OK");
    end
    $finish;
  end

endmodule
